// ----- hw/rtl/pckt_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the keyframe trigger.
package pckt_pkg;

    localparam int POS_W     = 32;
    localparam int QUAT_W    = 16;
    localparam int ANG_W     = 16;
    localparam int PITCH_W   = 15;
    localparam int MOVE_W    = 31;
    localparam int TURN_W    = 15;
    localparam int IN_W      = 3 * POS_W + 4 * QUAT_W;
    localparam int OUT_W     = 1 + 2 * ANG_W + PITCH_W;
    localparam int CFG_IDX_W = 1;

    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int IT_W         = $clog2(TAB_LEN);

    localparam int HALF_PI_Q20 = 1647099;
    localparam int Q13_PI      = 25736;
    localparam int Q13_HALF_PI = 12868;

    localparam logic [MOVE_W-1:0] MOVE_THR_RESET = MOVE_W'(26214);
    localparam logic [TURN_W-1:0] TURN_THR_RESET = TURN_W'(1393);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOVE_THR = 1'b0,
        REG_TURN_THR = 1'b1
    } cfg_reg_t;

    // Packed so that pos_x lands in the lowest bits of tdata.
    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_x;
    } item_t;

    typedef struct packed {
        logic [MOVE_W-1:0] move_thr;
        logic [TURN_W-1:0] turn_thr;
    } cfg_t;

    function automatic logic [19:0] atan_q20(input logic [IT_W-1:0] i);
        logic [19:0] v;
        case (i)
            5'd0:  v = 20'd823550;
            5'd1:  v = 20'd486170;
            5'd2:  v = 20'd256879;
            5'd3:  v = 20'd130396;
            5'd4:  v = 20'd65451;
            5'd5:  v = 20'd32757;
            5'd6:  v = 20'd16383;
            5'd7:  v = 20'd8192;
            5'd8:  v = 20'd4096;
            5'd9:  v = 20'd2048;
            5'd10: v = 20'd1024;
            5'd11: v = 20'd512;
            5'd12: v = 20'd256;
            5'd13: v = 20'd128;
            5'd14: v = 20'd64;
            5'd15: v = 20'd32;
            5'd16: v = 20'd16;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            5'd20: v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/pckt_front.sv -----
// Input side: accepts pose transfers and holds them in a two-entry queue.
module pckt_front
    import pckt_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,   // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    output logic            q_valid,
    input  logic            q_ready,
    output item_t           q_item
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= item_t'(s_tdata);
                wr_ptr_reg           <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- hw/rtl/pckt_back.sv -----
// Back end: shared multiplier, square root and CORDIC sequencer, decision and result register.
module pckt_back
    import pckt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  item_t            q_item,
    input  cfg_t             cfg,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SQRT, S_ANG_INIT, S_ANG_ITER, S_ANG_DONE, S_OUT
    } state_t;

    state_t                    state_reg;
    item_t                     item_reg;
    logic signed [31:0]        p_reg [9];
    logic signed [67:0]        prod_reg;
    logic [3:0]                cnt_reg;
    logic [63:0]               dsum_reg;
    logic [63:0]               thr2_reg;
    logic [56:0]               v_reg;
    logic [56:0]               r_reg;
    logic [56:0]               bit_reg;
    logic signed [37:0]        cx_reg;
    logic signed [37:0]        cy_reg;
    logic signed [25:0]        cz_reg;
    logic [IT_W-1:0]           it_reg;
    logic [1:0]                ang_idx_reg;
    logic signed [ANG_W-1:0]   ang_reg [3];
    logic signed [POS_W-1:0]   ref_pos_reg [3];
    logic signed [ANG_W-1:0]   ref_ang_reg [3];
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;

    logic signed [33:0]        op_a;
    logic signed [33:0]        op_b;
    logic signed [33:0]        s_val;
    logic                      s_pos_sat;
    logic                      s_neg_sat;
    logic [32:0]               dabs [3];
    logic signed [33:0]        arg_y;
    logic signed [33:0]        arg_x;
    logic [3:0]                cons_idx;
    logic [64:0]               dsum_wide;
    logic [56:0]               r_plus_bit;
    logic signed [26:0]        z_round;
    logic signed [19:0]        z_q13;
    logic signed [19:0]        ang_lim;
    logic signed [ANG_W-1:0]   ang_clamped;
    logic                      upd;
    logic                      out_free;

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // s = 2(wy - zx), valid once both products have been captured.
    assign s_val     = (34'(p_reg[4]) - 34'(p_reg[5])) <<< 1;
    assign s_pos_sat = (s_val >= 34'sd268435456);
    assign s_neg_sat = (s_val <= -34'sd268435456);

    always_comb begin
        logic signed [32:0] d;
        for (int i = 0; i < 3; i++) begin
            d       = 33'($signed(item_reg[i*POS_W +: POS_W])) - 33'(ref_pos_reg[i]);
            dabs[i] = d[32] ? 33'(-d) : 33'(d);
        end
    end

    // Operand selection for the shared multiplier, one product per cycle.
    always_comb begin
        op_a = s_val;
        op_b = s_val;
        case (cnt_reg)
            4'd0:  begin op_a = 34'(item_reg.quat_w); op_b = 34'(item_reg.quat_x); end
            4'd1:  begin op_a = 34'(item_reg.quat_y); op_b = 34'(item_reg.quat_z); end
            4'd2:  begin op_a = 34'(item_reg.quat_x); op_b = 34'(item_reg.quat_x); end
            4'd3:  begin op_a = 34'(item_reg.quat_y); op_b = 34'(item_reg.quat_y); end
            4'd4:  begin op_a = 34'(item_reg.quat_w); op_b = 34'(item_reg.quat_y); end
            4'd5:  begin op_a = 34'(item_reg.quat_z); op_b = 34'(item_reg.quat_x); end
            4'd6:  begin op_a = 34'(item_reg.quat_w); op_b = 34'(item_reg.quat_z); end
            4'd7:  begin op_a = 34'(item_reg.quat_x); op_b = 34'(item_reg.quat_y); end
            4'd8:  begin op_a = 34'(item_reg.quat_z); op_b = 34'(item_reg.quat_z); end
            4'd9:  begin op_a = $signed({1'b0, dabs[0]}); op_b = $signed({1'b0, dabs[0]}); end
            4'd10: begin op_a = $signed({1'b0, dabs[1]}); op_b = $signed({1'b0, dabs[1]}); end
            4'd11: begin op_a = $signed({1'b0, dabs[2]}); op_b = $signed({1'b0, dabs[2]}); end
            4'd12: begin
                op_a = $signed({3'b0, cfg.move_thr});
                op_b = $signed({3'b0, cfg.move_thr});
            end
            default: ;
        endcase
    end

    // atan2 arguments for roll, pitch and yaw.
    always_comb begin
        arg_y = (34'(p_reg[0]) + 34'(p_reg[1])) <<< 1;
        arg_x = 34'sd268435456 - ((34'(p_reg[2]) + 34'(p_reg[3])) <<< 1);
        case (ang_idx_reg)
            2'd1: begin
                arg_y = s_val;
                arg_x = $signed({5'b0, r_reg[28:0]});
            end
            2'd2: begin
                arg_y = (34'(p_reg[6]) + 34'(p_reg[7])) <<< 1;
                arg_x = 34'sd268435456 - ((34'(p_reg[3]) + 34'(p_reg[8])) <<< 1);
            end
            default: ;
        endcase
    end

    assign cons_idx   = cnt_reg - 4'd1;
    assign dsum_wide  = {1'b0, dsum_reg} + {1'b0, prod_reg[63:0]};
    assign r_plus_bit = r_reg + bit_reg;

    // Q20 to Q2.13 with rounding, then clamp to the angle's range.
    assign z_round = 27'(cz_reg) + 27'sd64;
    assign z_q13   = 20'(z_round >>> 7);
    assign ang_lim = (ang_idx_reg == 2'd1) ? 20'sd12868 : 20'sd25736;
    always_comb begin
        if (z_q13 > ang_lim) begin
            ang_clamped = ANG_W'(ang_lim);
        end else if (z_q13 < -ang_lim) begin
            ang_clamped = ANG_W'(-ang_lim);
        end else begin
            ang_clamped = ANG_W'(z_q13);
        end
    end

    always_comb begin
        logic signed [ANG_W:0] da;
        logic [ANG_W:0]        da_abs;
        upd = (dsum_reg >= thr2_reg);
        for (int i = 0; i < 3; i++) begin
            da     = (ANG_W+1)'(ang_reg[i]) - (ANG_W+1)'(ref_ang_reg[i]);
            da_abs = da[ANG_W] ? (ANG_W+1)'(-da) : (ANG_W+1)'(da);
            if (da_abs >= (ANG_W+1)'(cfg.turn_thr)) begin
                upd = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= 4'd0;
            ang_idx_reg  <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                ref_pos_reg[i] <= '0;
                ref_ang_reg[i] <= '0;
            end
        end else begin
            prod_reg <= op_a * op_b;
            // In S_OUT the output register is reloaded below whenever it is free.
            if (m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        cnt_reg   <= 4'd0;
                        dsum_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg != 4'd0) begin
                        case (cons_idx)
                            4'd9, 4'd10, 4'd11: begin
                                dsum_reg <= dsum_wide[64] ? '1 : dsum_wide[63:0];
                            end
                            4'd12: thr2_reg <= prod_reg[63:0];
                            4'd13: v_reg <= (57'd1 << 56) - prod_reg[56:0];
                            default: p_reg[cons_idx] <= prod_reg[31:0];
                        endcase
                    end
                    if (cnt_reg == 4'd14) begin
                        r_reg       <= '0;
                        bit_reg     <= 57'd1 << 56;
                        ang_idx_reg <= 2'd0;
                        state_reg   <= (s_pos_sat || s_neg_sat) ? S_ANG_INIT : S_SQRT;
                    end
                end
                S_SQRT: begin
                    // One result bit per cycle, bit walks down by two places.
                    if (v_reg >= r_plus_bit) begin
                        v_reg <= v_reg - r_plus_bit;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        state_reg <= S_ANG_INIT;
                    end
                end
                S_ANG_INIT: begin
                    it_reg <= '0;
                    if (ang_idx_reg == 2'd1 && (s_pos_sat || s_neg_sat)) begin
                        ang_reg[1]  <= s_pos_sat ? ANG_W'(Q13_HALF_PI) : ANG_W'(-Q13_HALF_PI);
                        ang_idx_reg <= 2'd2;
                    end else if (arg_x == '0 && arg_y == '0) begin
                        cz_reg    <= '0;
                        state_reg <= S_ANG_DONE;
                    end else begin
                        if (arg_x < 0) begin
                            if (arg_y >= 0) begin
                                cx_reg <= 38'(arg_y);
                                cy_reg <= -38'(arg_x);
                                cz_reg <= 26'(HALF_PI_Q20);
                            end else begin
                                cx_reg <= -38'(arg_y);
                                cy_reg <= 38'(arg_x);
                                cz_reg <= -26'(HALF_PI_Q20);
                            end
                        end else begin
                            cx_reg <= 38'(arg_x);
                            cy_reg <= 38'(arg_y);
                            cz_reg <= '0;
                        end
                        state_reg <= S_ANG_ITER;
                    end
                end
                S_ANG_ITER: begin
                    if (cy_reg > 0) begin
                        cx_reg <= cx_reg + (cy_reg >>> it_reg);
                        cy_reg <= cy_reg - (cx_reg >>> it_reg);
                        cz_reg <= cz_reg + $signed({6'b0, atan_q20(it_reg)});
                    end else begin
                        cx_reg <= cx_reg - (cy_reg >>> it_reg);
                        cy_reg <= cy_reg + (cx_reg >>> it_reg);
                        cz_reg <= cz_reg - $signed({6'b0, atan_q20(it_reg)});
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IT_W'(CORDIC_ITERS - 1)) begin
                        state_reg <= S_ANG_DONE;
                    end
                end
                S_ANG_DONE: begin
                    ang_reg[ang_idx_reg] <= ang_clamped;
                    if (ang_idx_reg == 2'd2) begin
                        state_reg <= S_OUT;
                    end else begin
                        ang_idx_reg <= ang_idx_reg + 2'd1;
                        state_reg   <= S_ANG_INIT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {ang_reg[2], ang_reg[1][PITCH_W-1:0], ang_reg[0], upd};
                        if (upd) begin
                            for (int i = 0; i < 3; i++) begin
                                ref_pos_reg[i] <= item_reg[i*POS_W +: POS_W];
                                ref_ang_reg[i] <= ang_reg[i];
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/pose_change_keyframe_trigger_unit.sv -----
// Top level of the keyframe trigger: configuration registers and the front and back ends.
// From input transfer to result: the products on the shared multiplier, the square root, then up to
// three CORDIC runs of 16 iterations (one per angle), plus load and output.
// The single shared CORDIC and multiplier handle one pose at a time; the next waits in the queue.
// The input queue holds two poses, so input transfers continue while a result waits.
// Reset (aresetn low, synchronous) restores default thresholds and zeroes the reference pose.
module pose_change_keyframe_trigger_unit
    import pckt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // update, roll, pitch, yaw
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MOVE_W-1:0]    cfg_wdata
);

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_thr <= MOVE_THR_RESET;
            cfg_reg.turn_thr <= TURN_THR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MOVE_THR: cfg_reg.move_thr <= cfg_wdata;
                REG_TURN_THR: cfg_reg.turn_thr <= cfg_wdata[TURN_W-1:0];
                default: ;
            endcase
        end
    end

    pckt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    pckt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
